### hdl/i2cm_pkg.sv
package i2cm_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [1:0] CSR_ACK_WAIT    = 2'd1;
   localparam logic [1:0] CSR_START_HOLD  = 2'd2;

   // Values held by the timing registers after reset.
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd1;
   localparam logic [7:0]  ACK_WAIT_RESET    = 8'd16;
   localparam logic [7:0]  START_HOLD_RESET  = 8'd8;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_STOP  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ST1   = 4'd1,
      PH_ST2   = 4'd2,
      PH_ST3   = 4'd3,
      PH_TXH   = 4'd4,
      PH_TXL   = 4'd5,
      PH_TXACK = 4'd6,
      PH_RXH   = 4'd7,
      PH_RXL   = 4'd8,
      PH_RXACK = 4'd9,
      PH_SP1   = 4'd10,
      PH_SP2   = 4'd11,
      PH_SP3   = 4'd12
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      op_type     operation;
      logic [6:0] target_address;
      logic       read_not_write;
      logic [7:0] write_byte;
      logic       ack_to_send;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_received;
   } rsp_type;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [7:0]  ack_wait_limit;
      logic [7:0]  start_hold_ticks;
   } cfg_type;

endpackage

### hdl/i2cm_if.sv
interface i2cm_req_if;
   logic              valid;
   logic              ready;
   i2cm_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface i2cm_rsp_if;
   logic              valid;
   logic              ready;
   i2cm_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/i2c_master_byte_engine.sv
// I2C master byte engine.
// The request channel carries one bus tick per transfer: an optional command
// (start plus address, write byte, read byte with the acknowledge to send, or
// stop) together with the sampled SDA level. Every request transfer produces
// exactly one response transfer holding the SCL level, the SDA pull-down, the
// busy and done flags, the last byte read and the last acknowledge received.
// Commands offered while a command is in progress are ignored.
// The sequencer state advances at the request transfer and the response is
// held in the output register from the next cycle.
// Throughput is one tick per cycle while the response receiver does not stall.
// The request channel stays ready while the output register is empty or is
// being emptied, so a stalled response receiver holds off further requests
// without losing any result.
// The csr port writes the half period, acknowledge wait limit and start hold
// registers; writes should be made while the engine is idle.
// A synchronous reset puts the sequencer in idle with both lines released,
// the acknowledge latch at NACK, the read byte cleared, the timing registers
// at 1, 16 and 8, and the response channel empty.
module i2c_master_byte_engine (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_ch,
   i2cm_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   i2cm_pkg::cfg_type cfg;
   i2cm_pkg::rsp_type step_rsp;
   logic              space;
   logic              step;

   // A request transfer takes place whenever a request is offered and the output register has room.
   assign req_ch.ready = space;
   assign step         = req_ch.valid && space;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ch.data),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   i2cm_out u_out (
      .clock (clock),
      .reset (reset),
      .load  (step),
      .din   (step_rsp),
      .space (space),
      .rsp   (rsp_ch)
   );

   // Every accepted tick must show up as a response in the next cycle.
   a_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_ch.valid)
      else $error("accepted request did not produce a response");

   // A response that is waiting must block further requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request accepted while response stalled");

   // A completing command leaves the engine idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.data.done_res) |-> !rsp_ch.data.busy_res)
      else $error("done reported while still busy");

   // A stalled response must not change under the receiver.
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(rsp_ch.data))
      else $error("stalled response changed");

endmodule

### hdl/i2cm_csr.sv
module i2cm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output i2cm_pkg::cfg_type cfg
);

   i2cm_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RESET;
         cfg_ff.ack_wait_limit    <= i2cm_pkg::ACK_WAIT_RESET;
         cfg_ff.start_hold_ticks  <= i2cm_pkg::START_HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cm_pkg::CSR_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_wdata;
            i2cm_pkg::CSR_ACK_WAIT:    cfg_ff.ack_wait_limit    <= csr_wdata[7:0];
            i2cm_pkg::CSR_START_HOLD:  cfg_ff.start_hold_ticks  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/i2cm_seq.sv
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  bit_ff, bit_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  wait_ff, wait_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic [7:0]  rd_ff, rd_in;
   logic        done;

   logic [15:0] len_raw, len;
   logic [7:0]  lim;
   logic [8:0]  wait_inc;
   logic [3:0]  bit_inc;
   logic [7:0]  shift_up;

   always_comb begin
      len_raw = (phase_ff inside {i2cm_pkg::PH_ST1, i2cm_pkg::PH_ST2, i2cm_pkg::PH_ST3})
                ? {8'd0, cfg.start_hold_ticks} : cfg.half_period_ticks;
      len      = (len_raw == 16'd0) ? 16'd1 : len_raw;
      lim      = (cfg.ack_wait_limit == 8'd0) ? 8'd1 : cfg.ack_wait_limit;
      wait_inc = {1'b0, wait_ff} + 9'd1;
      bit_inc  = bit_ff + 4'd1;
      shift_up = {shift_ff[6:0], 1'b0};

      phase_in = phase_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rd_in    = rd_ff;
      done     = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         if (req.cmd_valid) begin
            bit_in  = 4'd0;
            wait_in = 8'd0;
            tick_in = 16'd1;
            case (req.operation)
               i2cm_pkg::OP_START: begin
                  shift_in = {req.target_address, req.read_not_write};
                  phase_in = i2cm_pkg::PH_ST1;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               i2cm_pkg::OP_WRITE: begin
                  shift_in = req.write_byte;
                  phase_in = i2cm_pkg::PH_TXH;
                  scl_in   = 1'b1;
                  sda_in   = req.write_byte[7];
               end
               i2cm_pkg::OP_READ: begin
                  shift_in = 8'd0;
                  wait_in  = {7'd0, req.ack_to_send};
                  phase_in = i2cm_pkg::PH_RXH;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
               default: begin
                  phase_in = i2cm_pkg::PH_SP1;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
            endcase
         end
      end else if (phase_ff == i2cm_pkg::PH_TXACK) begin
         // Acknowledge poll: a low line ends it early, the limit ends it anyway.
         if (!req.sda_in || wait_inc >= {1'b0, lim}) begin
            ack_in   = req.sda_in;
            phase_in = i2cm_pkg::PH_IDLE;
            scl_in   = 1'b0;
            sda_in   = 1'b1;
            done     = 1'b1;
         end else begin
            wait_in = wait_inc[7:0];
         end
      end else if (tick_ff < len) begin
         tick_in = tick_ff + 16'd1;
      end else begin
         tick_in = 16'd1;
         case (phase_ff)
            i2cm_pkg::PH_ST1: begin
               phase_in = i2cm_pkg::PH_ST2;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
            end
            i2cm_pkg::PH_ST2: begin
               phase_in = i2cm_pkg::PH_ST3;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
            end
            i2cm_pkg::PH_ST3: begin
               bit_in   = 4'd0;
               phase_in = i2cm_pkg::PH_TXH;
               scl_in   = 1'b1;
               sda_in   = shift_ff[7];
            end
            i2cm_pkg::PH_TXH: begin
               phase_in = i2cm_pkg::PH_TXL;
               scl_in   = 1'b0;
            end
            i2cm_pkg::PH_TXL: begin
               shift_in = shift_up;
               bit_in   = bit_inc;
               scl_in   = 1'b1;
               if (bit_inc[3]) begin
                  wait_in  = 8'd0;
                  phase_in = i2cm_pkg::PH_TXACK;
                  sda_in   = 1'b1;
               end else begin
                  phase_in = i2cm_pkg::PH_TXH;
                  sda_in   = shift_up[7];
               end
            end
            i2cm_pkg::PH_RXH: begin
               shift_in = {shift_ff[6:0], req.sda_in};
               phase_in = i2cm_pkg::PH_RXL;
               scl_in   = 1'b0;
               sda_in   = 1'b1;
            end
            i2cm_pkg::PH_RXL: begin
               bit_in = bit_inc;
               scl_in = 1'b1;
               if (bit_inc[3]) begin
                  rd_in    = shift_ff;
                  phase_in = i2cm_pkg::PH_RXACK;
                  sda_in   = wait_ff[0];
               end else begin
                  phase_in = i2cm_pkg::PH_RXH;
                  sda_in   = 1'b1;
               end
            end
            i2cm_pkg::PH_RXACK: begin
               tick_in  = tick_ff;
               phase_in = i2cm_pkg::PH_IDLE;
               scl_in   = 1'b0;
               done     = 1'b1;
            end
            i2cm_pkg::PH_SP1: begin
               phase_in = i2cm_pkg::PH_SP2;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
            end
            i2cm_pkg::PH_SP2: begin
               phase_in = i2cm_pkg::PH_SP3;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
            end
            i2cm_pkg::PH_SP3: begin
               tick_in  = tick_ff;
               phase_in = i2cm_pkg::PH_IDLE;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
               done     = 1'b1;
            end
            default: begin
               tick_in  = tick_ff;
               phase_in = i2cm_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
         shift_ff <= 8'd0;
         bit_ff   <= 4'd0;
         tick_ff  <= 16'd0;
         wait_ff  <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b1;
         rd_ff    <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         wait_ff  <= wait_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         rd_ff    <= rd_in;
      end
   end

   // The result shows the line levels and latches as they stand after this tick.
   always_comb begin
      rsp.scl_out       = scl_in;
      rsp.sda_drive_low = ~sda_in;
      rsp.busy_res      = (phase_in != i2cm_pkg::PH_IDLE);
      rsp.done_res      = done;
      rsp.read_byte     = rd_in;
      rsp.ack_received  = ack_in;
   end

endmodule

### hdl/i2cm_out.sv
module i2cm_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  i2cm_pkg::rsp_type din,
   output logic              space,
   i2cm_rsp_if.source        rsp
);

   logic              valid_ff;
   i2cm_pkg::rsp_type data_ff;

   assign space = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= din;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.data  = data_ff;

endmodule

### tb/sv/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps

// Testbench for the I2C master byte engine.
// Every request transfer is one bus tick, and every tick yields exactly one
// response transfer, so the expected bus levels are worked out tick by tick
// as each request is accepted and queued until the matching response arrives.
module i2c_master_byte_engine_tb;

   // One row of the directed plan. Where typed is set, the last tick of the
   // row is checked against the value written into the row instead of the
   // value worked out by the bus model.
   typedef struct packed {
      bit                  set_timing;
      i2cm_pkg::cfg_type   timing;
      bit                  cmd_valid;
      i2cm_pkg::op_type    op;
      logic [6:0]          addr;
      logic                rnw;
      logic [7:0]          wbyte;
      logic                ack;
      logic [6:0]          high_pct;
      bit                  typed;
      i2cm_pkg::rsp_type   want;
   } step_row_type;

   localparam int PLAN_LEN = 25;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();

   i2c_master_byte_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Expected bus levels and status, one entry per accepted tick, oldest first.
   i2cm_pkg::rsp_type pending_lines [$];
   int unsigned mismatch_count = 0;
   int unsigned tick_total = 0;

   // While calm is set neither side idles, so that a long half period
   // setting runs at one tick per cycle.
   bit          calm = 1'b0;
   bit          tx_steady = 1'b0;
   int unsigned tx_span = 0;

   // Our own copy of the timing registers and of the bus sequencer.
   logic [15:0]         tm_half;
   logic [7:0]          tm_ackwait;
   logic [7:0]          tm_hold;
   i2cm_pkg::phase_type bus_phase;
   logic [7:0]          bus_shift;
   int unsigned         bus_bits;
   int unsigned         bus_ticks;
   int unsigned         bus_wait;
   logic                bus_scl;
   logic                bus_sda;
   logic                bus_ack;
   logic [7:0]          bus_rdbyte;

   // The directed plan: bus extremes, each command, commands offered with the
   // lines left in any state, zero timing registers and the largest settings.
   step_row_type plan [PLAN_LEN] = '{
      // After reset, no command: both lines released, acknowledge at NACK.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b0, i2cm_pkg::OP_START,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1}},
      // Start with the top address and a slave that never answers.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_START,
        7'h7F, 1'b1, 8'h00, 1'b0, 7'd100, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
      // All-zero byte, acknowledged at once.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'hFF, 1'b0, 7'd50, 1'b0, '0},
      // Acknowledge wait runs out with SDA high.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'hA5, 1'b0, 7'd100, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
      // Read of all ones, ACK sent: SDA is still pulled low at the end.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd100, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b1}},
      // Read of all zeros, NACK sent.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b1, 7'd0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      // Stop straight after a stop, then data commands with no start first.
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'h5A, 1'b0, 7'd90, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b1, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_START,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd0, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b0, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      // Zero in every timing register counts as one tick.
      '{1'b1, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'h3C, 1'b0, 7'd100, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_START,
        7'h55, 1'b1, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      // Longest acknowledge wait, run out with a silent slave.
      '{1'b1, '{16'd1, 8'd255, 8'd8}, 1'b1, i2cm_pkg::OP_START,
        7'h2A, 1'b0, 8'h00, 1'b0, 7'd100, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      // Longest half period, written and followed by an idle tick only, since
      // any command at that setting would run for far too many ticks.
      '{1'b1, '{16'd65535, 8'd1, 8'd1}, 1'b0, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0},
      '{1'b1, '{16'd3, 8'd1, 8'd1}, 1'b1, i2cm_pkg::OP_WRITE,
        7'h00, 1'b0, 8'hC3, 1'b0, 7'd100, 1'b0, '0},
      '{1'b1, '{16'd2, 8'd200, 8'd17}, 1'b1, i2cm_pkg::OP_START,
        7'h13, 1'b1, 8'h00, 1'b0, 7'd0, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_READ,
        7'h00, 1'b0, 8'h00, 1'b1, 7'd50, 1'b0, '0},
      '{1'b0, '{16'd0, 8'd0, 8'd0}, 1'b1, i2cm_pkg::OP_STOP,
        7'h00, 1'b0, 8'h00, 1'b0, 7'd50, 1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Bus model
   // ---------------------------------------------------------------------

   // Length of the current phase in ticks; a zero register counts as one.
   function automatic int unsigned phase_ticks();
      int unsigned n;
      n = (bus_phase inside {i2cm_pkg::PH_ST1, i2cm_pkg::PH_ST2, i2cm_pkg::PH_ST3})
          ? 32'(tm_hold) : 32'(tm_half);
      return (n == 0) ? 1 : n;
   endfunction

   function automatic void enter(i2cm_pkg::phase_type ph, logic scl, logic sda);
      bus_phase = ph;
      bus_ticks = 1;
      bus_scl   = scl;
      bus_sda   = sda;
   endfunction

   // Advances the sequencer by one tick and returns the levels and status
   // that the response for this tick must carry.
   function automatic i2cm_pkg::rsp_type bus_step(i2cm_pkg::req_type t);
      logic              done;
      int unsigned       lim;
      i2cm_pkg::rsp_type lines;
      done = 1'b0;
      if (bus_phase == i2cm_pkg::PH_IDLE) begin
         // A command is only taken up while idle.
         if (t.cmd_valid) begin
            bus_bits = 0;
            bus_wait = 0;
            case (t.operation)
               i2cm_pkg::OP_START: begin
                  bus_shift = {t.target_address, t.read_not_write};
                  enter(i2cm_pkg::PH_ST1, 1'b1, 1'b1);
               end
               i2cm_pkg::OP_WRITE: begin
                  bus_shift = t.write_byte;
                  enter(i2cm_pkg::PH_TXH, 1'b1, t.write_byte[7]);
               end
               i2cm_pkg::OP_READ: begin
                  // The accumulator is cleared and the wait counter holds the
                  // acknowledge level to send.
                  bus_shift = 8'h00;
                  bus_wait  = 32'(t.ack_to_send);
                  enter(i2cm_pkg::PH_RXH, 1'b1, 1'b1);
               end
               default: enter(i2cm_pkg::PH_SP1, 1'b0, 1'b0);
            endcase
         end
      end else if (bus_phase == i2cm_pkg::PH_TXACK) begin
         // Acknowledge poll: a low SDA ends it early, otherwise the level at
         // the limit is taken.
         lim = (tm_ackwait == 0) ? 1 : 32'(tm_ackwait);
         if (!t.sda_in || bus_wait + 1 >= lim) begin
            bus_ack   = t.sda_in;
            bus_phase = i2cm_pkg::PH_IDLE;
            bus_scl   = 1'b0;
            bus_sda   = 1'b1;
            done      = 1'b1;
         end else begin
            bus_wait++;
         end
      end else if (bus_ticks < phase_ticks()) begin
         bus_ticks++;
      end else begin
         case (bus_phase)
            i2cm_pkg::PH_ST1: enter(i2cm_pkg::PH_ST2, 1'b1, 1'b0);
            i2cm_pkg::PH_ST2: enter(i2cm_pkg::PH_ST3, 1'b0, 1'b0);
            i2cm_pkg::PH_ST3: begin
               bus_bits = 0;
               enter(i2cm_pkg::PH_TXH, 1'b1, bus_shift[7]);
            end
            i2cm_pkg::PH_TXH: enter(i2cm_pkg::PH_TXL, 1'b0, bus_sda);
            i2cm_pkg::PH_TXL: begin
               bus_shift = bus_shift << 1;
               bus_bits++;
               if (bus_bits >= 8) begin
                  bus_wait = 0;
                  enter(i2cm_pkg::PH_TXACK, 1'b1, 1'b1);
               end else begin
                  enter(i2cm_pkg::PH_TXH, 1'b1, bus_shift[7]);
               end
            end
            i2cm_pkg::PH_RXH: begin
               // Sampled on the tick the high phase ends, MSB first.
               bus_shift = {bus_shift[6:0], t.sda_in};
               enter(i2cm_pkg::PH_RXL, 1'b0, 1'b1);
            end
            i2cm_pkg::PH_RXL: begin
               bus_bits++;
               if (bus_bits >= 8) begin
                  bus_rdbyte = bus_shift;
                  enter(i2cm_pkg::PH_RXACK, 1'b1, bus_wait[0]);
               end else begin
                  enter(i2cm_pkg::PH_RXH, 1'b1, 1'b1);
               end
            end
            i2cm_pkg::PH_RXACK: begin
               bus_phase = i2cm_pkg::PH_IDLE;
               bus_scl   = 1'b0;
               done      = 1'b1;
            end
            i2cm_pkg::PH_SP1: enter(i2cm_pkg::PH_SP2, 1'b1, 1'b0);
            i2cm_pkg::PH_SP2: enter(i2cm_pkg::PH_SP3, 1'b1, 1'b0);
            i2cm_pkg::PH_SP3: begin
               bus_phase = i2cm_pkg::PH_IDLE;
               bus_scl   = 1'b1;
               bus_sda   = 1'b1;
               done      = 1'b1;
            end
            default: bus_phase = i2cm_pkg::PH_IDLE;
         endcase
      end
      lines.scl_out       = bus_scl;
      lines.sda_drive_low = ~bus_sda;
      lines.busy_res      = (bus_phase != i2cm_pkg::PH_IDLE);
      lines.done_res      = done;
      lines.read_byte     = bus_rdbyte;
      lines.ack_received  = bus_ack;
      return lines;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Picks the length of an idle stretch, now and then a long one.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // Chance in percent that SDA reads high on a tick; 100 makes the slave
   // silent, 0 makes it acknowledge at once.
   function automatic int unsigned pct_pick();
      case ($urandom_range(0, 4))
         0:       return 0;
         3:       return 90;
         4:       return 100;
         default: return 50;
      endcase
   endfunction

   function automatic i2cm_pkg::req_type random_tick(bit valid, i2cm_pkg::op_type op);
      logic [31:0]                          word;
      logic [$bits(i2cm_pkg::req_type)-1:0] raw;
      i2cm_pkg::req_type                    t;
      word        = $urandom;
      raw         = word[$bits(i2cm_pkg::req_type)-1:0];
      t           = raw;
      t.cmd_valid = valid;
      t.operation = op;
      return t;
   endfunction

   // Offers one tick and waits for its transfer, then steps the bus model.
   task automatic send_tick(input i2cm_pkg::req_type t, output i2cm_pkg::rsp_type lines);
      int unsigned gap;
      gap = 0;
      if (tx_span == 0) begin
         tx_span   = $urandom_range(40, 200);
         tx_steady = ($urandom_range(0, 3) == 0);
      end
      tx_span--;
      if (!calm && !tx_steady && $urandom_range(0, 3) == 0) begin
         gap = gap_len();
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      lines = bus_step(t);
      tick_total++;
   endtask

   // Sends a command tick and then further ticks until the sequencer is idle
   // again. Ticks sent while busy carry random fields, commands included, all
   // of which must be ignored.
   task automatic run_command(input i2cm_pkg::req_type cmd, input int unsigned high_pct,
                              input bit typed, input i2cm_pkg::rsp_type want);
      i2cm_pkg::req_type t;
      i2cm_pkg::rsp_type lines;
      t        = cmd;
      t.sda_in = ($urandom_range(0, 99) < high_pct);
      forever begin
         send_tick(t, lines);
         if (typed && bus_phase == i2cm_pkg::PH_IDLE) begin
            lines = want;
         end
         pending_lines.push_back(lines);
         if (bus_phase == i2cm_pkg::PH_IDLE) break;
         t        = random_tick(1'($urandom_range(0, 1)),
                                i2cm_pkg::op_type'($urandom_range(0, 3)));
         t.sda_in = ($urandom_range(0, 99) < high_pct);
      end
   endtask

   // Holds the sender off until every expected response has come back.
   task automatic drain_lines();
      req_ch.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
   endtask

   // Timing registers are only written with the engine idle and drained.
   task automatic apply_timing(input i2cm_pkg::cfg_type c);
      drain_lines();
      csr_we    <= 1'b1;
      csr_index <= i2cm_pkg::CSR_HALF_PERIOD;
      csr_wdata <= c.half_period_ticks;
      @(posedge clock);
      csr_index <= i2cm_pkg::CSR_ACK_WAIT;
      csr_wdata <= {8'h00, c.ack_wait_limit};
      @(posedge clock);
      csr_index <= i2cm_pkg::CSR_START_HOLD;
      csr_wdata <= {8'h00, c.start_hold_ticks};
      @(posedge clock);
      csr_we     <= 1'b0;
      tm_half    = c.half_period_ticks;
      tm_ackwait = c.ack_wait_limit;
      tm_hold    = c.start_hold_ticks;
      calm       = (c.half_period_ticks > 16'd255);
   endtask

   // Mostly well-formed transactions (start, one to three data bytes mostly in the
   // addressed direction, stop) with random content; the rest are lone
   // commands of any kind, offered whatever state the lines were left in.
   task automatic random_traffic(input int unsigned goal);
      int unsigned       stop_at;
      int unsigned       n;
      i2cm_pkg::req_type t;
      logic              rnw;
      i2cm_pkg::op_type  op;
      stop_at = tick_total + goal;
      while (tick_total < stop_at) begin
         if ($urandom_range(0, 4) != 0) begin
            t   = random_tick(1'b1, i2cm_pkg::OP_START);
            rnw = t.read_not_write;
            run_command(t, pct_pick(), 1'b0, '0);
            n = $urandom_range(1, 3);
            repeat (n) begin
               op = (rnw ^ ($urandom_range(0, 7) == 0)) ? i2cm_pkg::OP_READ
                                                        : i2cm_pkg::OP_WRITE;
               run_command(random_tick(1'b1, op), pct_pick(), 1'b0, '0);
            end
            run_command(random_tick(1'b1, i2cm_pkg::OP_STOP), pct_pick(), 1'b0, '0);
         end else begin
            op = i2cm_pkg::op_type'($urandom_range(0, 3));
            run_command(random_tick(1'b1, op), pct_pick(), 1'b0, '0);
         end
         n = $urandom_range(0, 2);
         repeat (n) run_command(random_tick(1'b0, i2cm_pkg::OP_START), 50, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and checking
   // ---------------------------------------------------------------------

   initial begin : rsp_pacing
      int unsigned hold;
      int unsigned span;
      bit          steady;
      hold   = 0;
      span   = 0;
      steady = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            span   = $urandom_range(50, 300);
            steady = ($urandom_range(0, 3) == 0);
         end
         span--;
         if (hold != 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            hold = gap_len() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         mismatch_count++;
      end
   endtask

   // Each response transfer is held against the oldest expectation.
   always @(posedge clock) begin : line_check
      i2cm_pkg::rsp_type want;
      i2cm_pkg::rsp_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = rsp_ch.data;
         if (pending_lines.size() == 0) begin
            $error("response transfer with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_lines.pop_front();
            compare_field("scl_out", {7'd0, want.scl_out}, {7'd0, seen.scl_out});
            compare_field("sda_drive_low", {7'd0, want.sda_drive_low},
                          {7'd0, seen.sda_drive_low});
            compare_field("busy_res", {7'd0, want.busy_res}, {7'd0, seen.busy_res});
            compare_field("done_res", {7'd0, want.done_res}, {7'd0, seen.done_res});
            compare_field("read_byte", want.read_byte, seen.read_byte);
            compare_field("ack_received", {7'd0, want.ack_received},
                          {7'd0, seen.ack_received});
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin : main_flow
      i2cm_pkg::req_type t;
      i2cm_pkg::cfg_type c;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= i2cm_pkg::CSR_HALF_PERIOD;
      csr_wdata    <= 16'h0000;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;

      // State after reset.
      tm_half    = i2cm_pkg::HALF_PERIOD_RESET;
      tm_ackwait = i2cm_pkg::ACK_WAIT_RESET;
      tm_hold    = i2cm_pkg::START_HOLD_RESET;
      bus_phase  = i2cm_pkg::PH_IDLE;
      bus_shift  = 8'h00;
      bus_bits   = 0;
      bus_ticks  = 0;
      bus_wait   = 0;
      bus_scl    = 1'b1;
      bus_sda    = 1'b1;
      bus_ack    = 1'b1;
      bus_rdbyte = 8'h00;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed plan, with the timing registers at their reset values
      // until a row says otherwise.
      foreach (plan[i]) begin
         if (plan[i].set_timing) begin
            apply_timing(plan[i].timing);
         end
         t                = random_tick(plan[i].cmd_valid, plan[i].op);
         t.target_address = plan[i].addr;
         t.read_not_write = plan[i].rnw;
         t.write_byte     = plan[i].wbyte;
         t.ack_to_send    = plan[i].ack;
         run_command(t, 32'(plan[i].high_pct), plan[i].typed, plan[i].want);
      end

      // Random traffic under a handful of short timing settings; a zero in a
      // register and the longest acknowledge wait turn up now and then.
      repeat (5) begin
         c.half_period_ticks = 16'($urandom_range(0, 3));
         c.ack_wait_limit    = ($urandom_range(0, 5) == 0) ? 8'd255
                                                           : 8'($urandom_range(0, 20));
         c.start_hold_ticks  = 8'($urandom_range(0, 5));
         apply_timing(c);
         random_traffic(50);
      end

      // Let the last responses come back, then watch the output register for any stray transfer.
      drain_lines();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_lines.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Ends the run as failed if the main sequence hangs.
   initial begin : watchdog
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
